// ===== hdl/lgw_pkg.sv =====
// Shared types, codes and the grid row table of the LED grid frame writer.
`timescale 1ns / 1ps

package lgw_pkg;

  // Item commands
  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_LOAD    = 2'd1,
    CMD_REFRESH = 2'd2
  } lgw_cmd_e;

  // Configuration register indexes
  localparam logic [1:0] CFG_DATA_CMD  = 2'd0;
  localparam logic [1:0] CFG_DISP_CTRL = 2'd1;

  localparam int unsigned NUM_ROWS = 11;
  localparam int unsigned ROW_AW   = $clog2(NUM_ROWS);

  localparam logic [7:0] ADDR_BYTE   = 8'hC0;
  localparam logic [7:0] FILLER_BYTE = 8'hFF;

  // One result word
  typedef struct packed {
    logic clock_level;
    logic data_level;
    logic busy_res;
    logic frame_done;
  } lgw_res_t;

  // Grid slot to row mapping
  typedef struct packed {
    logic              filler;
    logic [ROW_AW-1:0] row;
  } lgw_slot_t;

  function automatic lgw_slot_t grid_slot(input logic [3:0] k);
    lgw_slot_t s;
    s.filler = 1'b0;
    s.row    = '0;
    case (k)
      4'd0:  s.row = 4'd10;
      4'd1:  s.row = 4'd9;
      4'd7:  s.row = 4'd5;
      4'd8:  s.row = 4'd6;
      4'd9:  s.row = 4'd7;
      4'd10: s.row = 4'd8;
      4'd11: s.row = 4'd4;
      4'd12: s.row = 4'd3;
      4'd13: s.row = 4'd2;
      4'd14: s.row = 4'd1;
      4'd15: s.row = 4'd0;
      default: s.filler = 1'b1;
    endcase
    return s;
  endfunction

endpackage

// ===== hdl/lgw_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module lgw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hdl/lgw_seq.sv =====
// Pin sequencer: start, byte and end phases of the three frame transactions.
`timescale 1ns / 1ps

module lgw_seq (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  lgw_pkg::lgw_cmd_e          cmd_i,
  input  logic [7:0]                 data_cmd_i,
  input  logic [7:0]                 disp_ctrl_i,
  input  logic [7:0]                 row_byte_i,
  output logic [lgw_pkg::ROW_AW-1:0] rd_addr_o,
  output logic                       sending_o,
  output lgw_pkg::lgw_res_t          res_o
);

  logic [1:0] tx_q, tx_d;
  logic [4:0] byte_q, byte_d;
  logic [3:0] phase_q, phase_d;
  logic [7:0] shift_q, shift_d;
  logic       clk_q, clk_d;
  logic       dat_q, dat_d;
  logic       send_q, send_d;
  logic       done;

  logic [4:0]        nbytes;
  logic [7:0]        cur_byte;
  logic [7:0]        bit_src;
  lgw_pkg::lgw_slot_t cur_slot;
  lgw_pkg::lgw_slot_t nxt_slot;
  logic [4:0]        cur_k;
  logic [4:0]        nxt_k;

  // Byte that begins now; row data was fetched from the next-state address
  assign cur_k    = byte_q - 5'd2;
  assign cur_slot = lgw_pkg::grid_slot(cur_k[3:0]);
  assign nbytes   = (tx_q == 2'd1) ? 5'd17 : 5'd1;

  always_comb begin
    if (tx_q == 2'd0) begin
      cur_byte = data_cmd_i;
    end else if (tx_q != 2'd1) begin
      cur_byte = disp_ctrl_i;
    end else if (byte_q <= 5'd1) begin
      cur_byte = lgw_pkg::ADDR_BYTE;
    end else if (cur_slot.filler) begin
      cur_byte = lgw_pkg::FILLER_BYTE;
    end else begin
      cur_byte = row_byte_i;
    end
  end

  assign bit_src = (phase_q == 4'd0) ? cur_byte : shift_q;

  // Next state of the pin sequence
  always_comb begin
    tx_d    = tx_q;
    byte_d  = byte_q;
    phase_d = phase_q;
    shift_d = shift_q;
    clk_d   = clk_q;
    dat_d   = dat_q;
    send_d  = send_q;
    done    = 1'b0;
    if (step_i) begin
      case (cmd_i)
        lgw_pkg::CMD_TICK: begin
          if (send_q) begin
            if (byte_q == 5'd0) begin
              // start condition
              case (phase_q[1:0])
                2'd0:    dat_d = 1'b1;
                2'd1:    clk_d = 1'b1;
                2'd2:    dat_d = 1'b0;
                default: clk_d = 1'b0;
              endcase
              if (phase_q[1:0] == 2'd3) begin
                phase_d = '0;
                byte_d  = 5'd1;
              end else begin
                phase_d = phase_q + 4'd1;
              end
            end else if (byte_q <= nbytes) begin
              // data bits, LSB first
              if (!phase_q[0]) begin
                clk_d   = 1'b0;
                dat_d   = bit_src[0];
                shift_d = bit_src;
              end else begin
                clk_d   = 1'b1;
                shift_d = {1'b0, shift_q[7:1]};
              end
              if (phase_q == 4'd15) begin
                phase_d = '0;
                byte_d  = byte_q + 5'd1;
              end else begin
                phase_d = phase_q + 4'd1;
              end
            end else begin
              // end condition
              case (phase_q[1:0])
                2'd0:    clk_d = 1'b0;
                2'd1:    dat_d = 1'b0;
                2'd2:    clk_d = 1'b1;
                default: dat_d = 1'b1;
              endcase
              if (phase_q[1:0] == 2'd3) begin
                phase_d = '0;
                byte_d  = '0;
                if (tx_q >= 2'd2) begin
                  tx_d   = '0;
                  send_d = 1'b0;
                  done   = 1'b1;
                end else begin
                  tx_d = tx_q + 2'd1;
                end
              end else begin
                phase_d = phase_q + 4'd1;
              end
            end
          end
        end
        lgw_pkg::CMD_REFRESH: begin
          if (!send_q) begin
            send_d  = 1'b1;
            tx_d    = '0;
            byte_d  = '0;
            phase_d = '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Prefetch address for the byte that the next state will begin
  assign nxt_k     = byte_d - 5'd2;
  assign nxt_slot  = lgw_pkg::grid_slot(nxt_k[3:0]);
  assign rd_addr_o = nxt_slot.filler ? '0 : nxt_slot.row;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_q    <= '0;
      byte_q  <= '0;
      phase_q <= '0;
      shift_q <= '0;
      clk_q   <= 1'b1;
      dat_q   <= 1'b1;
      send_q  <= 1'b0;
    end else begin
      tx_q    <= tx_d;
      byte_q  <= byte_d;
      phase_q <= phase_d;
      shift_q <= shift_d;
      clk_q   <= clk_d;
      dat_q   <= dat_d;
      send_q  <= send_d;
    end
  end

  assign sending_o         = send_q;
  assign res_o.clock_level = clk_d;
  assign res_o.data_level  = dat_d;
  assign res_o.busy_res    = send_d;
  assign res_o.frame_done  = done;

endmodule

// ===== hdl/led_grid_frame_serial_writer.sv =====
// Top level of the LED grid frame writer: config, row RAM, sequencer, output word.
// The result word of an accepted item is captured in the output register at its accepting edge.
// Throughput: one item per cycle while the output register is not stalled; the sequencer
// updates its pin state per item; the row RAM is read ahead from the next-state byte address.
// Reset: asynchronous active low; pins high, idle, config 0x40 / 0x8F, all rows read as zero
// through per-row valid bits, so there is no clearing pass.
`timescale 1ns / 1ps

module led_grid_frame_serial_writer (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input words
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] command_i,
  input  logic [3:0] row_index_i,
  input  logic [7:0] row_value_i,
  // result words
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       clock_level_o,
  output logic       data_level_o,
  output logic       busy_res_o,
  output logic       frame_done_o,
  // configuration writes
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  logic [7:0] data_cmd_q;
  logic [7:0] disp_ctrl_q;

  logic                         step;
  lgw_pkg::lgw_cmd_e            cmd;
  logic                         sending;
  logic                         row_we;
  logic [lgw_pkg::ROW_AW-1:0]   rd_addr;
  logic [7:0]                   ram_rdata;
  logic [lgw_pkg::NUM_ROWS-1:0] row_vld_q;
  logic                         rd_vld_q;
  logic [7:0]                   row_byte;
  lgw_pkg::lgw_res_t            res;
  lgw_pkg::lgw_res_t            out_q;
  logic                         out_valid_q;

  // Handshake: output register frees up when it is empty or taken
  assign in_stall_o = out_valid_q && out_stall_i;
  assign step       = in_valid_i && !in_stall_o;
  assign cmd        = lgw_pkg::lgw_cmd_e'(command_i);

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_cmd_q  <= 8'h40;
      disp_ctrl_q <= 8'h8F;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == lgw_pkg::CFG_DATA_CMD) begin
        data_cmd_q <= cfg_data_i;
      end else if (cfg_index_i == lgw_pkg::CFG_DISP_CTRL) begin
        disp_ctrl_q <= cfg_data_i;
      end
    end
  end

  // Row store: loads only while idle and in range
  assign row_we = step && (cmd == lgw_pkg::CMD_LOAD) && !sending &&
                  (row_index_i < 4'(lgw_pkg::NUM_ROWS));

  lgw_ram #(
    .WIDTH (8),
    .DEPTH (lgw_pkg::NUM_ROWS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (row_index_i[lgw_pkg::ROW_AW-1:0]),
    .wdata_i (row_value_i),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // Valid bits: a row never loaded reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (row_we) begin
        row_vld_q[row_index_i[lgw_pkg::ROW_AW-1:0]] <= 1'b1;
      end
      rd_vld_q <= row_vld_q[rd_addr];
    end
  end

  assign row_byte = rd_vld_q ? ram_rdata : 8'h00;

  lgw_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .cmd_i       (cmd),
    .data_cmd_i  (data_cmd_q),
    .disp_ctrl_i (disp_ctrl_q),
    .row_byte_i  (row_byte),
    .rd_addr_o   (rd_addr),
    .sending_o   (sending),
    .res_o       (res)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign clock_level_o = out_q.clock_level;
  assign data_level_o  = out_q.data_level;
  assign busy_res_o    = out_q.busy_res;
  assign frame_done_o  = out_q.frame_done;

endmodule

// ===== hdl/lgw_checker.sv =====
// Port-level checker for the LED grid frame writer, bound to the top level.
`timescale 1ns / 1ps

module lgw_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       clock_level_o,
  input logic       data_level_o,
  input logic       busy_res_o,
  input logic       frame_done_o
);

  // Stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(busy_res_o) &&
      $stable(frame_done_o) && $stable(clock_level_o) && $stable(data_level_o)))
    else $error("stalled result word changed");

  // Accepted word always produces a result word next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> out_valid_o)
    else $error("accepted word produced no result");

  // No input taken while a result waits stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("input accepted while output stalled");

  // Frame end leaves the bus idle with both pins high
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_done_o) |-> (!busy_res_o && clock_level_o && data_level_o))
    else $error("frame end without idle bus");

endmodule

bind led_grid_frame_serial_writer lgw_checker u_lgw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .clock_level_o (clock_level_o),
  .data_level_o  (data_level_o),
  .busy_res_o    (busy_res_o),
  .frame_done_o  (frame_done_o)
);
